/* rtl/core/ray_sphere_intersection_top_defines.svh */
// Assertion macros for the ray/sphere intersection block.
// Included by the top level; no other dependencies.
`ifndef RAY_SPHERE_INTERSECTION_TOP_DEFINES_SVH
`define RAY_SPHERE_INTERSECTION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RSI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("rsi check failed");
`define RSI_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rsi reset check failed");
`else
`define RSI_ASSERT(lbl, clk, rstn, prop)
`define RSI_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* rtl/core/rsi_pkg.sv */
// Package for the ray/sphere intersection block: widths, payload and job types.
// No dependencies.
package rsi_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIR_W    = 16;
  localparam int unsigned DIR_FRAC = 14;
  localparam int unsigned RAD_W    = COORD_W - 1;
  localparam int unsigned V_W      = COORD_W + 1;
  localparam int unsigned PD_W     = V_W + DIR_W;
  localparam int unsigned PV_W     = 2 * V_W;
  localparam int unsigned DOT_W    = PD_W + 2;
  localparam int unsigned DIST2_W  = PV_W + 2;
  localparam int unsigned R2_W     = 2 * RAD_W;
  localparam int unsigned E_W      = DIST2_W + 1;
  localparam int unsigned LO_W     = (DOT_W + 1) / 2;
  localparam int unsigned HI_W     = DOT_W - LO_W;
  localparam int unsigned DOT2_W   = 2 * DOT_W;
  localparam int unsigned Q_W      = DOT2_W + 2;
  localparam int unsigned SQ_W     = Q_W / 2;
  localparam int unsigned RES_W    = SQ_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [DIR_W-1:0]   dir_x;
    logic signed [DIR_W-1:0]   dir_y;
    logic signed [DIR_W-1:0]   dir_z;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RAD_W-1:0]          radius;
  } rsi_req_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] near_distance;
    logic signed [COORD_W-1:0] far_distance;
  } rsi_res_t;

  typedef struct packed {
    logic                    early_miss;
    logic signed [DOT_W-1:0] dot;
    logic [DIST2_W-1:0]      dist2;
    logic [R2_W-1:0]         r2;
  } rsi_job_t;

  typedef struct packed {
    logic                    miss;
    logic signed [DOT_W-1:0] dot;
  } rsi_tag_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rsi_qstat_t;

endpackage

/* rtl/core/rsi_front.sv */
// Front end: forms V, dot, dist2 and r2 over three stages and flags early misses.
// Depends on rsi_pkg.
module rsi_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rsi_pkg::rsi_req_t req_i,
  input  logic             stall_i,
  output logic             out_valid_o,
  output rsi_pkg::rsi_job_t job_o
);
  import rsi_pkg::*;

  logic                      adv;
  logic                      a_valid_q, b_valid_q, c_valid_q;
  logic signed [V_W-1:0]     v_d [3];
  logic signed [V_W-1:0]     v_q [3];
  logic signed [DIR_W-1:0]   d_q [3];
  logic [RAD_W-1:0]          rad_q;
  logic signed [PD_W-1:0]    pd_d [3];
  logic signed [PD_W-1:0]    pd_q [3];
  logic signed [PV_W-1:0]    pv_d [3];
  logic signed [PV_W-1:0]    pv_q [3];
  logic [R2_W-1:0]           rr_d, rr_q;
  logic signed [DOT_W-1:0]   dot_d, dot_q;
  logic [DIST2_W-1:0]        dist2_d, dist2_q;
  logic [R2_W-1:0]           r2_q;

  assign adv = !stall_i;

  always_comb begin
    v_d[0] = V_W'(req_i.center_x) - V_W'(req_i.origin_x);
    v_d[1] = V_W'(req_i.center_y) - V_W'(req_i.origin_y);
    v_d[2] = V_W'(req_i.center_z) - V_W'(req_i.origin_z);
    for (int i = 0; i < 3; i++) begin
      pd_d[i] = v_q[i] * d_q[i];
      pv_d[i] = v_q[i] * v_q[i];
    end
    rr_d    = rad_q * rad_q;
    dot_d   = DOT_W'(pd_q[0]) + DOT_W'(pd_q[1]) + DOT_W'(pd_q[2]);
    dist2_d = DIST2_W'(unsigned'(pv_q[0])) + DIST2_W'(unsigned'(pv_q[1]))
            + DIST2_W'(unsigned'(pv_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= in_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_q     <= v_d;
      d_q[0]  <= req_i.dir_x;
      d_q[1]  <= req_i.dir_y;
      d_q[2]  <= req_i.dir_z;
      rad_q   <= req_i.radius;
      pd_q    <= pd_d;
      pv_q    <= pv_d;
      rr_q    <= rr_d;
      dot_q   <= dot_d;
      dist2_q <= dist2_d;
      r2_q    <= rr_q;
    end
  end

  assign out_valid_o      = c_valid_q;
  assign job_o.early_miss = (dist2_q >= DIST2_W'(r2_q)) && dot_q[DOT_W-1];
  assign job_o.dot        = dot_q;
  assign job_o.dist2      = dist2_q;
  assign job_o.r2         = r2_q;

endmodule

/* rtl/core/rsi_queue.sv */
// Short job queue between the front and back ends; registered read port.
// Depends on rsi_pkg.
module rsi_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rsi_pkg::rsi_job_t  job_i,
  output logic               out_valid_o,
  output rsi_pkg::rsi_job_t  job_o,
  output rsi_pkg::rsi_qstat_t stat_o
);
  import rsi_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rsi_job_t         mem_q [DEPTH];
  rsi_job_t         job_q;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             valid_q;
  logic             push_ok, pop;

  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign push_ok      = push_i && !stat_o.full;
  assign pop          = !stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= job_i;
    end
    job_q <= mem_q[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= pop;
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      case ({push_ok, pop})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign out_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

/* rtl/core/rsi_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with a side-band tag.
// Depends on rsi_pkg.
module rsi_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  rsi_pkg::rsi_tag_t         tag_i,
  input  logic [rsi_pkg::Q_W-1:0]   rad_i,
  output logic                      valid_o,
  output rsi_pkg::rsi_tag_t         tag_o,
  output logic [rsi_pkg::SQ_W-1:0]  root_o
);
  import rsi_pkg::*;

  logic             valid_q [SQ_W];
  rsi_tag_t         tag_q   [SQ_W];
  logic [Q_W-1:0]   rem_q   [SQ_W];
  logic [SQ_W-1:0]  root_q  [SQ_W];
  logic             valid_in [SQ_W];
  rsi_tag_t         tag_in   [SQ_W];
  logic [Q_W-1:0]   rem_in   [SQ_W];
  logic [SQ_W-1:0]  root_in  [SQ_W];
  logic [Q_W-1:0]   trial    [SQ_W];
  logic [Q_W-1:0]   rem_d    [SQ_W];
  logic [SQ_W-1:0]  root_d   [SQ_W];

  always_comb begin
    valid_in[0] = valid_i;
    tag_in[0]   = tag_i;
    rem_in[0]   = rad_i;
    root_in[0]  = '0;
    for (int k = 1; k < SQ_W; k++) begin
      valid_in[k] = valid_q[k-1];
      tag_in[k]   = tag_q[k-1];
      rem_in[k]   = rem_q[k-1];
      root_in[k]  = root_q[k-1];
    end
    for (int k = 0; k < SQ_W; k++) begin
      trial[k] = (Q_W'(root_in[k]) << (SQ_W - k)) | (Q_W'(1) << (2 * (SQ_W - 1 - k)));
      if (rem_in[k] >= trial[k]) begin
        rem_d[k]  = rem_in[k] - trial[k];
        root_d[k] = root_in[k] | (SQ_W'(1) << (SQ_W - 1 - k));
      end else begin
        rem_d[k]  = rem_in[k];
        root_d[k] = root_in[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQ_W; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else begin
      valid_q <= valid_in;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_in;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign valid_o = valid_q[SQ_W-1];
  assign tag_o   = tag_q[SQ_W-1];
  assign root_o  = root_q[SQ_W-1];

endmodule

/* rtl/core/rsi_back.sv */
// Back end: squares dot in partial products, forms q, takes its root, saturates.
// Depends on rsi_pkg and rsi_sqrt.
module rsi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  rsi_pkg::rsi_job_t job_i,
  output logic              done_o,
  output rsi_pkg::rsi_res_t res_o
);
  import rsi_pkg::*;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [RES_W-1:0] x);
    logic signed [RES_W-1:0] maxv;
    logic signed [RES_W-1:0] minv;
    logic signed [RES_W-1:0] y;
    maxv = signed'({{(RES_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}});
    minv = signed'({{(RES_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}});
    y = x;
    if (x > maxv) y = maxv;
    if (x < minv) y = minv;
    return y[COORD_W-1:0];
  endfunction

  logic                      v1_q, v2_q, v3_q, v4_q, done_q;
  rsi_tag_t                  tag1_q, tag2_q, tag3_q, tag4_q;
  logic [DOT_W-1:0]          mag1_q;
  logic signed [E_W-1:0]     e1_q, e2_q, e3_q;
  logic [2*HI_W-1:0]         hh_q;
  logic [HI_W+LO_W-1:0]      hl_q;
  logic [2*LO_W-1:0]         ll_q;
  logic [DOT2_W-1:0]         dot2_q;
  logic signed [Q_W-1:0]     q_d, q_q;
  logic                      sq_valid;
  rsi_tag_t                  sq_tag;
  logic [SQ_W-1:0]           sq_root;
  logic signed [RES_W-1:0]   dot_x, root_x, near_x, far_x;
  rsi_res_t                  res_d, res_q;

  assign q_d = signed'(Q_W'(dot2_q)) - (Q_W'(e3_q) <<< (2 * DIR_FRAC));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      done_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q.miss <= job_i.early_miss;
    tag1_q.dot  <= job_i.dot;
    mag1_q      <= job_i.dot[DOT_W-1] ? unsigned'(-job_i.dot) : unsigned'(job_i.dot);
    e1_q        <= signed'(E_W'(job_i.dist2)) - signed'(E_W'(job_i.r2));
    tag2_q      <= tag1_q;
    e2_q        <= e1_q;
    hh_q        <= mag1_q[DOT_W-1:LO_W] * mag1_q[DOT_W-1:LO_W];
    hl_q        <= mag1_q[DOT_W-1:LO_W] * mag1_q[LO_W-1:0];
    ll_q        <= mag1_q[LO_W-1:0] * mag1_q[LO_W-1:0];
    tag3_q      <= tag2_q;
    e3_q        <= e2_q;
    dot2_q      <= (DOT2_W'(hh_q) << (2 * LO_W)) + (DOT2_W'(hl_q) << (LO_W + 1))
                 + DOT2_W'(ll_q);
    tag4_q.dot  <= tag3_q.dot;
    tag4_q.miss <= tag3_q.miss || q_d[Q_W-1];
    q_q         <= q_d;
    res_q       <= res_d;
  end

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .tag_i   (tag4_q),
    .rad_i   (unsigned'(q_q)),
    .valid_o (sq_valid),
    .tag_o   (sq_tag),
    .root_o  (sq_root)
  );

  always_comb begin
    dot_x  = RES_W'(sq_tag.dot);
    root_x = signed'(RES_W'(sq_root));
    near_x = (dot_x - root_x) >>> DIR_FRAC;
    far_x  = (dot_x + root_x) >>> DIR_FRAC;
    if (sq_tag.miss) begin
      res_d.hit           = 1'b0;
      res_d.near_distance = '0;
      res_d.far_distance  = '0;
    end else begin
      res_d.hit           = 1'b1;
      res_d.near_distance = sat(near_x);
      res_d.far_distance  = sat(far_x);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

/* rtl/core/ray_sphere_intersection_top.sv */
// Top level of the ray/sphere intersection block: front end, job queue, back end.
// Depends on rsi_pkg, rsi_front, rsi_queue, rsi_back and the defines header.
//
// Use: drive req_i with origin, direction (Q2.14), centre and radius and raise
// start; a query transfers at each rising edge with start high and busy low.
// Each query gives one result on res_o, marked by done_o for exactly one
// cycle: hit, with near and far distances (Q16.16, saturated), both zero on
// a miss. Results come out in query order and cannot be held off.
// Path: a query passes the front end (three stages), the queue write and its
// registered read, four back-end stages, the 52-stage root pipeline and the
// output register; a query can transfer in every cycle while busy is low.
// busy rises only when the four-entry queue is full with a front-end item
// waiting; as the back end drains one job a cycle, this does not occur in
// normal operation.
// Reset clears all valid bits and the queue; nothing is in flight afterwards.
`include "ray_sphere_intersection_top_defines.svh"
module ray_sphere_intersection_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rsi_pkg::rsi_req_t req_i,
  output logic              done_o,
  output rsi_pkg::rsi_res_t res_o
);
  import rsi_pkg::*;

  logic       f_valid;
  rsi_job_t   f_job;
  logic       q_valid;
  rsi_job_t   q_job;
  rsi_qstat_t q_stat;

  assign busy = f_valid && q_stat.full;

  rsi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start && !busy),
    .req_i       (req_i),
    .stall_i     (busy),
    .out_valid_o (f_valid),
    .job_o       (f_job)
  );

  rsi_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .job_i       (f_job),
    .out_valid_o (q_valid),
    .job_o       (q_job),
    .stat_o      (q_stat)
  );

  rsi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .job_i      (q_job),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  `RSI_ASSERT(a_miss_zero, clk_i, rst_ni, (done_o && !res_o.hit) |-> (res_o.near_distance == '0 && res_o.far_distance == '0))
  `RSI_ASSERT(a_hit_order, clk_i, rst_ni, (done_o && res_o.hit) |-> (res_o.near_distance <= res_o.far_distance))
  `RSI_ASSERT(a_hold_on_full, clk_i, rst_ni, (f_valid && q_stat.full) |=> f_valid)
  `RSI_ASSERT_RST(a_quiet_in_reset, clk_i, !rst_ni |-> !done_o)

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for ray_sphere_intersection_top: directed and random ray queries.
// Predicts each result in wide fixed point and compares it with the block's output.
// Depends on rsi_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
  import rsi_pkg::*;

  localparam int unsigned WW       = 200;
  localparam int unsigned N_RANDOM = 1700;
  localparam int unsigned LIMIT    = 400000;
  localparam int unsigned LATENCY  = 61;
  localparam int unsigned REQ_W    = $bits(rsi_req_t);

  typedef logic signed [WW-1:0] wide_t;

  class hit_scoreboard;
    rsi_res_t expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned hits;

    function wide_t root_floor(wide_t q);
      wide_t res;
      wide_t t;
      res = '0;
      for (int i = 60; i >= 0; i--) begin
        t = res | (wide_t'(1) << i);
        if (t * t <= q) res = t;
      end
      return res;
    endfunction

    function logic signed [COORD_W-1:0] clamp(wide_t x);
      wide_t hi;
      wide_t lo;
      hi = wide_t'(32'sh7fffffff);
      lo = -wide_t'(64'sh80000000);
      if (x > hi) x = hi;
      if (x < lo) x = lo;
      return x[COORD_W-1:0];
    endfunction

    function rsi_res_t predict(rsi_req_t r);
      wide_t vx, vy, vz, dot, dist2, r2, dot2, dist2s, r2s, q, s, rad;
      rsi_res_t res;
      res = '0;
      vx = wide_t'(r.center_x) - wide_t'(r.origin_x);
      vy = wide_t'(r.center_y) - wide_t'(r.origin_y);
      vz = wide_t'(r.center_z) - wide_t'(r.origin_z);
      dot = vx * wide_t'(r.dir_x) + vy * wide_t'(r.dir_y) + vz * wide_t'(r.dir_z);
      dist2 = vx * vx + vy * vy + vz * vz;
      rad = wide_t'({1'b0, r.radius});
      r2 = rad * rad;
      dot2 = dot * dot;
      dist2s = dist2 <<< (2 * DIR_FRAC);
      r2s = r2 <<< (2 * DIR_FRAC);
      if (dist2 >= r2) begin
        if (dot < 0) return res;
        if (r2s < dist2s - dot2) return res;
      end
      q = dot2 - (dist2s - r2s);
      if (q < 0) return res;
      s = root_floor(q);
      res.hit = 1'b1;
      res.near_distance = clamp((dot - s) >>> DIR_FRAC);
      res.far_distance = clamp((dot + s) >>> DIR_FRAC);
      return res;
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH %0d: %s", errors, what);
    endtask

    function void note_query(rsi_req_t r);
      expected_q.push_back(predict(r));
    endfunction

    task check_result(rsi_res_t got);
      rsi_res_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (exp.hit) hits++;
      if (got.hit !== exp.hit)
        report($sformatf("hit %b, want %b", got.hit, exp.hit));
      if (got.near_distance !== exp.near_distance)
        report($sformatf("near %h, want %h", got.near_distance, exp.near_distance));
      if (got.far_distance !== exp.far_distance)
        report($sformatf("far %h, want %h", got.far_distance, exp.far_distance));
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  rsi_req_t req_i;
  logic     done_o;
  rsi_res_t res_o;

  hit_scoreboard sb;
  int unsigned cycles = 0;

  ray_sphere_intersection_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_query(req_i);
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  task send_query(rsi_req_t r);
    logic b;
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
      if (!b) break;
    end
  endtask

  task hold_off(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function rsi_req_t make_query(int ox, oy, oz, int dx, dy, dz, int cx, cy, cz, int rad);
    rsi_req_t r;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    r.center_x = cx; r.center_y = cy; r.center_z = cz;
    r.radius = RAD_W'(rad);
    return r;
  endfunction

  function void unit_dir(real x, real y, real z, output logic signed [15:0] dx, dy, dz);
    real len;
    len = $sqrt(x * x + y * y + z * z);
    if (len == 0.0) begin
      x = 1.0; len = 1.0;
    end
    dx = 16'($rtoi(16384.0 * x / len));
    dy = 16'($rtoi(16384.0 * y / len));
    dz = 16'($rtoi(16384.0 * z / len));
  endfunction

  function real rnd_unit();
    return ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
  endfunction

  function rsi_req_t random_query();
    rsi_req_t r;
    int unsigned kind;
    int signed span;
    logic signed [15:0] dx, dy, dz;
    logic signed [31:0] offx, offy, offz;
    kind = $urandom_range(0, 9);
    r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom});
    if (kind < 7) begin
      span = 1 << $urandom_range(8, 24);
      offx = $signed($urandom_range(0, 2 * span)) - span;
      offy = $signed($urandom_range(0, 2 * span)) - span;
      offz = $signed($urandom_range(0, 2 * span)) - span;
      r.center_x = $signed($urandom) >>> 2;
      r.center_y = $signed($urandom) >>> 2;
      r.center_z = $signed($urandom) >>> 2;
      r.origin_x = r.center_x + offx;
      r.origin_y = r.center_y + offy;
      r.origin_z = r.center_z + offz;
      r.radius = RAD_W'($urandom_range(0, 2 * span));
      if (kind < 5)
        unit_dir(-$itor(offx) + rnd_unit() * span, -$itor(offy) + rnd_unit() * span,
                 -$itor(offz) + rnd_unit() * span, dx, dy, dz);
      else
        unit_dir(rnd_unit(), rnd_unit(), rnd_unit(), dx, dy, dz);
      r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    end else if (kind == 7) begin
      r.dir_x = '0; r.dir_y = '0; r.dir_z = '0;
    end
    return r;
  endfunction

  initial begin
    rsi_req_t directed[$];
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back('0);
    directed.push_back(make_query(0, 0, 0, 16384, 0, 0, 5 << 16, 3 << 16, 0, 3 << 16));
    directed.push_back(make_query(0, 0, 0, 16384, 0, 0, 5 << 16, 0, 0, 2 << 16));
    directed.push_back(make_query(0, 0, 0, -16384, 0, 0, 5 << 16, 0, 0, 2 << 16));
    directed.push_back(make_query(0, 0, 0, 0, 16384, 0, 5 << 16, 0, 0, 2 << 16));
    directed.push_back(make_query(1 << 16, 0, 0, 0, 0, 16384, 0, 0, 0, 4 << 16));
    directed.push_back(make_query(1 << 16, 0, 0, 0, 0, 0, 0, 0, 0, 4 << 16));
    directed.push_back(make_query(8 << 16, 0, 0, 0, 0, 0, 0, 0, 0, 4 << 16));
    directed.push_back(make_query(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                  16'sh7fff, 16'sh7fff, 16'sh7fff,
                                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '1));
    directed.push_back(make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                  16'sh8000, 16'sh8000, 16'sh8000,
                                  32'sh80000000, 32'sh80000000, 32'sh80000000, '1));
    directed.push_back(make_query(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000,
                                  0, 0, 0, 31'h7fffffff));
    directed.push_back(make_query(32'sh80000000, 0, 0, 16384, 0, 0, 32'sh7fffffff, 0, 0, 1));
    directed.push_back(make_query(0, 0, 0, 16384, 0, 0, 3 << 16, 0, 0, 3 << 16));
    foreach (directed[i]) send_query(directed[i]);
    hold_off(1);
    while (sb.pending() != 0) @(posedge clk_i);

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      send_query(random_query());
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end else if (n < N_RANDOM - 300 && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 9));
      end
    end
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report("results still outstanding at end");

    $display("Checked %0d results (%0d hits), directed edge cases and %0d random rays.",
             sb.checked, sb.hits, N_RANDOM);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/rsi_pkg.sv
rtl/core/rsi_front.sv
rtl/core/rsi_queue.sv
rtl/core/rsi_sqrt.sv
rtl/core/rsi_back.sv
rtl/core/ray_sphere_intersection_top.sv
tb/sv/testbench.sv
